@@ rtl/assert_macros.svh @@
// Assertion macros used by the port checker of this project.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising clock edge, skipped while reset is low.
`define PRST_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// Check a property on every rising clock edge, reset included.
`define PRST_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ rtl/prst_pkg.sv @@
// ----------------------------------------------------------------------------
// prst_pkg
// Types, codes and the CRC8 step helper for the probe ROM staging table.
// ----------------------------------------------------------------------------
package prst_pkg;

  // Default table size and fixed field widths
  localparam int unsigned ProbeCountDefault = 8;
  localparam int unsigned RomWidth          = 64;
  localparam int unsigned GeomWidth         = 16;
  localparam logic [7:0]  FamilyCode        = 8'h28;
  localparam logic [7:0]  CrcPoly           = 8'h8C;
  localparam logic [15:0] AcceptedGeomReset = 16'd1;
  // CRC covers bytes 0 to 6, four bits per step
  localparam logic [3:0]  CrcLastStep       = 4'd13;

  typedef enum logic [1:0] {
    CMD_BEGIN  = 2'd0,
    CMD_STAGE  = 2'd1,
    CMD_FINISH = 2'd2,
    CMD_ABORT  = 2'd3
  } cmd_e;

  typedef enum logic [2:0] {
    ST_OK           = 3'd0,
    ST_NOT_STAGING  = 3'd1,
    ST_BAD_POSITION = 3'd2,
    ST_BAD_FAMILY   = 3'd3,
    ST_BAD_CRC      = 3'd4,
    ST_DUPLICATE    = 3'd5,
    ST_INCOMPLETE   = 3'd6,
    ST_BAD_GEOMETRY = 3'd7
  } status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DECODE,
    S_CRC,
    S_DUP,
    S_RESP,
    S_EMIT
  } state_e;

  // Advance the reflected CRC8 by four data bits, LSB first
  function automatic logic [7:0] crc_nibble(input logic [7:0] crc_in, input logic [3:0] data);
    logic [7:0] crc;
    logic       mix;
    crc = crc_in;
    for (int b = 0; b < 4; b++) begin
      mix = crc[0] ^ data[b];
      crc = {1'b0, crc[7:1]};
      if (mix) begin
        crc = crc ^ CrcPoly;
      end
    end
    return crc;
  endfunction

endpackage

@@ rtl/probe_rom_staging_table.sv @@
// ----------------------------------------------------------------------------
// probe_rom_staging_table
// Staging table for 64-bit sensor ROM codes: checks family and CRC8, rejects
// duplicates, and reads the full table out on finish.
// ----------------------------------------------------------------------------
//
// Channel  Direction  Handshake            Beat contents
// in       sink       in_valid_i/in_stall_o    cmd, position, rom, geometry
// out      source     out_valid_o/out_stall_i  status, slot, rom, geometry, mask, last
// cfg      sink       cfg_valid_i/cfg_ready_o  accepted geometry id
//
// Begin, abort and errors found at decode pass from decode straight to the
// response state. Stage runs a 4-bit-per-cycle CRC8 step over bytes 0 to 6,
// then one duplicate compare per table entry. Finish emits one beat per cycle
// after decode while the output register is not holding a stalled beat.
// Input is stalled while an item is in work; the output register holds a
// stalled beat and only the cycle that writes a new beat waits for it.
// Reset initialises all control state; the table itself is gated by the set bits.

module probe_rom_staging_table #(
  parameter int unsigned PROBE_COUNT = prst_pkg::ProbeCountDefault
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // Input beats
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [1:0]  cmd_i,
  input  logic [7:0]  position_i,
  input  logic [63:0] rom_i,
  input  logic [15:0] geometry_i,
  // Result beats
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [2:0]  status_o,
  output logic [3:0]  slot_number_o,
  output logic [63:0] rom_out_o,
  output logic [15:0] geometry_out_o,
  output logic [7:0]  filled_mask_o,
  output logic        last_o,
  // Configuration
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [15:0] cfg_data_i
);

  localparam int unsigned IdxW = (PROBE_COUNT > 1) ? $clog2(PROBE_COUNT) : 1;
  localparam logic [IdxW-1:0] IdxLast = IdxW'(PROBE_COUNT - 1);

  // Control state
  prst_pkg::state_e  state_q, state_d;
  logic              active_q, active_d;
  logic [15:0]       staged_geom_q, staged_geom_d;
  logic [PROBE_COUNT-1:0] set_bits_q, set_bits_d;
  logic [15:0]       acc_geom_q;
  logic              out_valid_q, out_valid_d;

  // Item registers
  prst_pkg::cmd_e    cmd_q, cmd_d;
  logic [7:0]        pos_q, pos_d;
  logic [63:0]       rom_q, rom_d;
  logic [15:0]       geom_q, geom_d;
  logic [IdxW-1:0]   target_q, target_d;
  logic [IdxW-1:0]   idx_q, idx_d;
  logic [3:0]        cnt_q, cnt_d;
  logic [7:0]        crc_q, crc_d;
  logic [7:0]        crc_next;
  prst_pkg::status_e res_status_q, res_status_d;

  // Output register
  prst_pkg::status_e o_status_q, o_status_d;
  logic [3:0]        o_slot_q, o_slot_d;
  logic [63:0]       o_rom_q, o_rom_d;
  logic [15:0]       o_geom_q, o_geom_d;
  logic [7:0]        o_mask_q, o_mask_d;
  logic              o_last_q, o_last_d;

  // Table
  logic [63:0]       store_q [PROBE_COUNT];
  logic [63:0]       store_rd;
  logic              store_we;
  logic              out_free;

  assign store_rd  = store_q[idx_q];
  assign out_free  = !out_valid_q || !out_stall_i;
  assign crc_next  = prst_pkg::crc_nibble(crc_q, rom_q[{cnt_q, 2'b00} +: 4]);

  // Sequencer: next state and datapath controls
  always_comb begin
    state_d       = state_q;
    active_d      = active_q;
    staged_geom_d = staged_geom_q;
    set_bits_d    = set_bits_q;
    out_valid_d   = out_valid_q;
    cmd_d         = cmd_q;
    pos_d         = pos_q;
    rom_d         = rom_q;
    geom_d        = geom_q;
    target_d      = target_q;
    idx_d         = idx_q;
    cnt_d         = cnt_q;
    crc_d         = crc_q;
    res_status_d  = res_status_q;
    o_status_d    = o_status_q;
    o_slot_d      = o_slot_q;
    o_rom_d       = o_rom_q;
    o_geom_d      = o_geom_q;
    o_mask_d      = o_mask_q;
    o_last_d      = o_last_q;
    store_we      = 1'b0;

    // Drop the output beat once taken
    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      prst_pkg::S_IDLE: begin
        if (in_valid_i) begin
          cmd_d   = prst_pkg::cmd_e'(cmd_i);
          pos_d   = position_i;
          rom_d   = rom_i;
          geom_d  = geometry_i;
          state_d = prst_pkg::S_DECODE;
        end
      end

      prst_pkg::S_DECODE: begin
        state_d = prst_pkg::S_RESP;
        case (cmd_q)
          prst_pkg::CMD_BEGIN: begin
            set_bits_d    = '0;
            active_d      = 1'b1;
            staged_geom_d = geom_q;
            res_status_d  = prst_pkg::ST_OK;
          end
          prst_pkg::CMD_ABORT: begin
            set_bits_d    = '0;
            active_d      = 1'b0;
            staged_geom_d = '0;
            res_status_d  = prst_pkg::ST_OK;
          end
          prst_pkg::CMD_STAGE: begin
            target_d = pos_q[IdxW-1:0] - IdxW'(1);
            if (!active_q) begin
              res_status_d = prst_pkg::ST_NOT_STAGING;
            end else if (pos_q == 8'd0 || pos_q > 8'(PROBE_COUNT)) begin
              res_status_d = prst_pkg::ST_BAD_POSITION;
            end else if (rom_q[7:0] != prst_pkg::FamilyCode) begin
              res_status_d = prst_pkg::ST_BAD_FAMILY;
            end else begin
              crc_d   = '0;
              cnt_d   = '0;
              state_d = prst_pkg::S_CRC;
            end
          end
          prst_pkg::CMD_FINISH: begin
            if (!active_q) begin
              res_status_d = prst_pkg::ST_NOT_STAGING;
            end else if (set_bits_q != '1) begin
              res_status_d = prst_pkg::ST_INCOMPLETE;
            end else if (staged_geom_q != acc_geom_q) begin
              res_status_d = prst_pkg::ST_BAD_GEOMETRY;
            end else begin
              idx_d   = '0;
              state_d = prst_pkg::S_EMIT;
            end
          end
          default: begin
            state_d = prst_pkg::S_IDLE;
          end
        endcase
      end

      // Four CRC bits per cycle over bytes 0 to 6
      prst_pkg::S_CRC: begin
        crc_d = crc_next;
        cnt_d = cnt_q + 4'd1;
        if (cnt_q == prst_pkg::CrcLastStep) begin
          if (crc_next != rom_q[63:56]) begin
            res_status_d = prst_pkg::ST_BAD_CRC;
            state_d      = prst_pkg::S_RESP;
          end else begin
            idx_d   = '0;
            state_d = prst_pkg::S_DUP;
          end
        end
      end

      // Compare one table entry per cycle; commit unless a duplicate is found
      prst_pkg::S_DUP: begin
        if (idx_q != target_q && set_bits_q[idx_q] && store_rd == rom_q) begin
          res_status_d = prst_pkg::ST_DUPLICATE;
          state_d      = prst_pkg::S_RESP;
        end else if (idx_q == IdxLast) begin
          store_we             = 1'b1;
          set_bits_d[target_q] = 1'b1;
          res_status_d         = prst_pkg::ST_OK;
          state_d              = prst_pkg::S_RESP;
        end else begin
          idx_d = idx_q + IdxW'(1);
        end
      end

      prst_pkg::S_RESP: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          o_status_d  = res_status_q;
          o_slot_d    = '0;
          o_rom_d     = '0;
          o_geom_d    = '0;
          o_mask_d    = 8'(set_bits_q);
          o_last_d    = 1'b1;
          state_d     = prst_pkg::S_IDLE;
        end
      end

      // Emit one table entry per beat
      prst_pkg::S_EMIT: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          o_status_d  = prst_pkg::ST_OK;
          o_slot_d    = 4'(idx_q) + 4'd1;
          o_rom_d     = store_rd;
          o_geom_d    = staged_geom_q;
          o_mask_d    = 8'(set_bits_q);
          o_last_d    = (idx_q == IdxLast);
          if (idx_q == IdxLast) begin
            state_d = prst_pkg::S_IDLE;
          end else begin
            idx_d = idx_q + IdxW'(1);
          end
        end
      end

      default: begin
        state_d = prst_pkg::S_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= prst_pkg::S_IDLE;
      active_q      <= 1'b0;
      staged_geom_q <= '0;
      set_bits_q    <= '0;
      out_valid_q   <= 1'b0;
      acc_geom_q    <= prst_pkg::AcceptedGeomReset;
    end else begin
      state_q       <= state_d;
      active_q      <= active_d;
      staged_geom_q <= staged_geom_d;
      set_bits_q    <= set_bits_d;
      out_valid_q   <= out_valid_d;
      if (cfg_valid_i) begin
        acc_geom_q <= cfg_data_i;
      end
    end
  end

  // Item and output payload registers
  always_ff @(posedge clk_i) begin
    cmd_q        <= cmd_d;
    pos_q        <= pos_d;
    rom_q        <= rom_d;
    geom_q       <= geom_d;
    target_q     <= target_d;
    idx_q        <= idx_d;
    cnt_q        <= cnt_d;
    crc_q        <= crc_d;
    res_status_q <= res_status_d;
    o_status_q   <= o_status_d;
    o_slot_q     <= o_slot_d;
    o_rom_q      <= o_rom_d;
    o_geom_q     <= o_geom_d;
    o_mask_q     <= o_mask_d;
    o_last_q     <= o_last_d;
  end

  // Table write on a committed stage
  always_ff @(posedge clk_i) begin
    if (store_we) begin
      store_q[target_q] <= rom_q;
    end
  end

  assign in_stall_o     = (state_q != prst_pkg::S_IDLE);
  assign cfg_ready_o    = 1'b1;
  assign out_valid_o    = out_valid_q;
  assign status_o       = o_status_q;
  assign slot_number_o  = o_slot_q;
  assign rom_out_o      = o_rom_q;
  assign geometry_out_o = o_geom_q;
  assign filled_mask_o  = o_mask_q;
  assign last_o         = o_last_q;

endmodule

@@ rtl/prst_checker.sv @@
// ----------------------------------------------------------------------------
// prst_checker
// Port-level checks for the probe ROM staging table, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module prst_port_checker #(
  parameter int unsigned PROBE_COUNT = prst_pkg::ProbeCountDefault
) (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        out_valid_o,
  input logic        out_stall_i,
  input logic [2:0]  status_o,
  input logic [3:0]  slot_number_o,
  input logic [63:0] rom_out_o,
  input logic        last_o
);

  // Hold a stalled result beat
  `PRST_ASSERT(a_out_hold, clk_i, rst_ni, out_valid_o && out_stall_i |=> out_valid_o && $stable(rom_out_o) && $stable(slot_number_o), "stalled result beat changed")

  // Error results are single beats
  `PRST_ASSERT(a_err_last, clk_i, rst_ni, out_valid_o && status_o != prst_pkg::ST_OK |-> last_o && slot_number_o == 4'd0, "error result not a single last beat")

  // Emitted slots stay within the table
  `PRST_ASSERT(a_slot_range, clk_i, rst_ni, out_valid_o |-> slot_number_o <= 4'(PROBE_COUNT), "slot number beyond table size")

  // The final emitted entry is the last slot
  `PRST_ASSERT(a_emit_last, clk_i, rst_ni, out_valid_o && slot_number_o != 4'd0 && last_o |-> slot_number_o == 4'(PROBE_COUNT), "last flag on wrong slot")

endmodule

bind probe_rom_staging_table prst_port_checker #(
  .PROBE_COUNT (PROBE_COUNT)
) u_prst_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .out_valid_o   (out_valid_o),
  .out_stall_i   (out_stall_i),
  .status_o      (status_o),
  .slot_number_o (slot_number_o),
  .rom_out_o     (rom_out_o),
  .last_o        (last_o)
);

@@ dv/prst_tb_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// prst_tb_pkg
// Beat types and the ROM CRC8 used by the staging table testbench: the
// stimulus builds well-formed ROM codes with it and the checker predicts
// stage results with it.
// ----------------------------------------------------------------------------
package prst_tb_pkg;

  import prst_pkg::*;

  // One command beat as offered on the input channel
  typedef struct packed {
    cmd_e        cmd;
    logic [7:0]  position;
    logic [63:0] rom;
    logic [15:0] geometry;
  } probe_cmd_t;

  // One result beat as expected on the output channel
  typedef struct packed {
    status_e     status;
    logic [3:0]  slot;
    logic [63:0] rom;
    logic [15:0] geometry;
    logic [7:0]  mask;
    logic        last;
  } table_beat_t;

  // Dallas/Maxim CRC8 over ROM bytes 0 to 6, one bit at a time, LSB first
  function automatic logic [7:0] rom_crc8(input logic [63:0] rom);
    logic [7:0] crc;
    logic       mix;
    crc = 8'h00;
    for (int i = 0; i < 56; i++) begin
      mix = crc[0] ^ rom[i];
      crc = crc >> 1;
      if (mix) begin
        crc = crc ^ CrcPoly;
      end
    end
    return crc;
  endfunction

endpackage

@@ dv/prst_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// prst_checker
// Passive checker for the probe ROM staging table. Watches the input, output
// and configuration channels, keeps its own copy of the table state, predicts
// the result beats of every accepted command and compares them in order.
// ----------------------------------------------------------------------------
module prst_checker
  import prst_pkg::*;
  import prst_tb_pkg::*;
#(
  parameter int unsigned PROBE_COUNT = ProbeCountDefault
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  input  logic        in_stall_i,
  input  logic [1:0]  cmd_i,
  input  logic [7:0]  position_i,
  input  logic [63:0] rom_i,
  input  logic [15:0] geometry_i,
  input  logic        out_valid_i,
  input  logic        out_stall_i,
  input  logic [2:0]  status_i,
  input  logic [3:0]  slot_number_i,
  input  logic [63:0] rom_out_i,
  input  logic [15:0] geometry_out_i,
  input  logic [7:0]  filled_mask_i,
  input  logic        last_i,
  input  logic        cfg_valid_i,
  input  logic        cfg_ready_i,
  input  logic [15:0] cfg_data_i,
  output int          fail_count_o,
  output int          pending_o,
  output int          in_beats_o,
  output int          out_beats_o,
  output int          readouts_o
);

  localparam logic [7:0] FullMask = 8'((1 << PROBE_COUNT) - 1);

  // Shadow copy of the table and the accepted geometry register
  logic        table_active;
  logic [15:0] table_geom;
  logic [7:0]  table_filled;
  logic [63:0] table_roms [PROBE_COUNT];
  logic [15:0] accepted_geom;

  table_beat_t table_beats_q [$];
  table_beat_t head_beat;

  // Status of a stage command against the current shadow table
  function automatic status_e stage_status(input logic [7:0] pos, input logic [63:0] rom);
    status_e st;
    st = ST_OK;
    if (!table_active) begin
      st = ST_NOT_STAGING;
    end else if (pos == 8'd0 || int'(pos) > PROBE_COUNT) begin
      st = ST_BAD_POSITION;
    end else if (rom[7:0] != FamilyCode) begin
      st = ST_BAD_FAMILY;
    end else if (rom_crc8(rom) != rom[63:56]) begin
      st = ST_BAD_CRC;
    end else begin
      for (int k = 0; k < PROBE_COUNT; k++) begin
        if (k != int'(pos) - 1 && table_filled[k] && table_roms[k] == rom) begin
          st = ST_DUPLICATE;
        end
      end
    end
    return st;
  endfunction

  // Clear the whole shadow table
  task automatic clear_table();
    for (int k = 0; k < PROBE_COUNT; k++) begin
      table_roms[k] = '0;
    end
    table_filled = '0;
  endtask

  // Update the shadow table for one command and queue its result beats
  task automatic predict_table_op(input cmd_e cmd, input logic [7:0] pos,
                                  input logic [63:0] rom, input logic [15:0] geom);
    table_beat_t beat;
    status_e     st;
    logic        readout;
    beat    = '0;
    readout = 1'b0;
    st      = ST_OK;
    case (cmd)
      CMD_BEGIN: begin
        clear_table();
        table_active = 1'b1;
        table_geom   = geom;
      end
      CMD_STAGE: begin
        st = stage_status(pos, rom);
        if (st == ST_OK) begin
          table_roms[pos - 8'd1]   = rom;
          table_filled[pos - 8'd1] = 1'b1;
        end
      end
      CMD_FINISH: begin
        if (!table_active) begin
          st = ST_NOT_STAGING;
        end else if ((table_filled & FullMask) != FullMask) begin
          st = ST_INCOMPLETE;
        end else if (table_geom != accepted_geom) begin
          st = ST_BAD_GEOMETRY;
        end else begin
          readout = 1'b1;
        end
      end
      default: begin
        clear_table();
        table_active = 1'b0;
        table_geom   = '0;
      end
    endcase
    if (readout) begin
      // Emit every entry in position order, last flag on the final one
      for (int k = 0; k < PROBE_COUNT; k++) begin
        beat.status   = ST_OK;
        beat.slot     = 4'(k + 1);
        beat.rom      = table_roms[k];
        beat.geometry = table_geom;
        beat.mask     = table_filled;
        beat.last     = (k == PROBE_COUNT - 1);
        table_beats_q.push_back(beat);
      end
    end else begin
      beat.status = st;
      beat.mask   = table_filled;
      beat.last   = 1'b1;
      table_beats_q.push_back(beat);
    end
  endtask

  task automatic check_field(input string name, input logic [63:0] exp_val,
                             input logic [63:0] act_val);
    if (exp_val !== act_val) begin
      $error("%s mismatch: expected 0x%0h, actual 0x%0h", name, exp_val, act_val);
      fail_count_o++;
    end
  endtask

  // Compare result beats, track register writes, predict command beats
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      clear_table();
      table_active  = 1'b0;
      table_geom    = '0;
      accepted_geom = AcceptedGeomReset;
      table_beats_q.delete();
      fail_count_o  = 0;
      in_beats_o    = 0;
      out_beats_o   = 0;
      readouts_o    = 0;
    end else begin
      if (out_valid_i && !out_stall_i) begin
        out_beats_o++;
        if (table_beats_q.size() == 0) begin
          $error("unexpected result beat: status %0d slot %0d rom 0x%0h",
                 status_i, slot_number_i, rom_out_i);
          fail_count_o++;
        end else begin
          head_beat = table_beats_q.pop_front();
          check_field("status", 64'(head_beat.status), 64'(status_i));
          check_field("slot_number", 64'(head_beat.slot), 64'(slot_number_i));
          check_field("rom_out", head_beat.rom, rom_out_i);
          check_field("geometry_out", 64'(head_beat.geometry), 64'(geometry_out_i));
          check_field("filled_mask", 64'(head_beat.mask), 64'(filled_mask_i));
          check_field("last", 64'(head_beat.last), 64'(last_i));
          if (head_beat.last && head_beat.slot == 4'(PROBE_COUNT)) begin
            readouts_o++;
          end
        end
      end
      if (cfg_valid_i && cfg_ready_i) begin
        accepted_geom = cfg_data_i;
      end
      if (in_valid_i && !in_stall_i) begin
        in_beats_o++;
        predict_table_op(cmd_e'(cmd_i), position_i, rom_i, geometry_i);
      end
    end
    pending_o = table_beats_q.size();
  end

endmodule

@@ dv/tb_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Stimulus and verdict for the probe ROM staging table. A directed pass walks
// every command and error status but bad geometry, then random phases under
// several accepted geometry settings mostly build full tables with injected
// faults, mixed with noise commands. Input beats come in bursts, the output
// stalls on changing patterns; one long output hold-off backs up the block.
// ----------------------------------------------------------------------------
module tb_top;

  import prst_pkg::*;
  import prst_tb_pkg::*;

  localparam int unsigned ProbeCount = ProbeCountDefault;
  localparam int          PhaseItems = 66;
  localparam int          HoldCycles = 400;

  typedef enum int {
    STALL_NONE,
    STALL_LIGHT,
    STALL_HEAVY,
    STALL_PERIODIC
  } stall_mode_e;

  logic        clk_i          = 1'b0;
  logic        rst_ni         = 1'b0;
  logic        in_valid_i     = 1'b0;
  logic        in_stall_o;
  logic [1:0]  cmd_i          = '0;
  logic [7:0]  position_i     = '0;
  logic [63:0] rom_i          = '0;
  logic [15:0] geometry_i     = '0;
  logic        out_valid_o;
  logic        out_stall_i    = 1'b0;
  logic [2:0]  status_o;
  logic [3:0]  slot_number_o;
  logic [63:0] rom_out_o;
  logic [15:0] geometry_out_o;
  logic [7:0]  filled_mask_o;
  logic        last_o;
  logic        cfg_valid_i    = 1'b0;
  logic        cfg_ready_o;
  logic [15:0] cfg_data_i     = '0;

  int fail_count;
  int pending;
  int in_beats;
  int out_beats;
  int readouts;

  probe_cmd_t  cmd_q [$];
  probe_cmd_t  cur_cmd;
  int          burst_left   = 0;
  int          gap_left     = 0;
  int          queued_items = 0;
  int          cfg_writes   = 0;
  logic        hold_req     = 1'b0;
  logic        hold_done    = 1'b0;
  int          hold_left    = 0;
  stall_mode_e stall_mode   = STALL_NONE;
  int          mode_left    = 0;
  int          stall_tick   = 0;

  probe_rom_staging_table #(
    .PROBE_COUNT(ProbeCount)
  ) i_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .cmd_i          (cmd_i),
    .position_i     (position_i),
    .rom_i          (rom_i),
    .geometry_i     (geometry_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .status_o       (status_o),
    .slot_number_o  (slot_number_o),
    .rom_out_o      (rom_out_o),
    .geometry_out_o (geometry_out_o),
    .filled_mask_o  (filled_mask_o),
    .last_o         (last_o),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_ready_o    (cfg_ready_o),
    .cfg_data_i     (cfg_data_i)
  );

  prst_checker #(
    .PROBE_COUNT(ProbeCount)
  ) i_checker (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_i     (in_stall_o),
    .cmd_i          (cmd_i),
    .position_i     (position_i),
    .rom_i          (rom_i),
    .geometry_i     (geometry_i),
    .out_valid_i    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .status_i       (status_o),
    .slot_number_i  (slot_number_o),
    .rom_out_i      (rom_out_o),
    .geometry_out_i (geometry_out_o),
    .filled_mask_i  (filled_mask_o),
    .last_i         (last_o),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_ready_i    (cfg_ready_o),
    .cfg_data_i     (cfg_data_i),
    .fail_count_o   (fail_count),
    .pending_o      (pending),
    .in_beats_o     (in_beats),
    .out_beats_o    (out_beats),
    .readouts_o     (readouts)
  );

  // Clock: 10 ns period
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Offer queued commands in bursts with random gaps; hold a stalled beat
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else if (!(in_valid_i && in_stall_o)) begin
      if (gap_left > 0) begin
        gap_left--;
        in_valid_i <= 1'b0;
      end else if (cmd_q.size() > 0) begin
        cur_cmd = cmd_q.pop_front();
        cmd_i      <= cur_cmd.cmd;
        position_i <= cur_cmd.position;
        rom_i      <= cur_cmd.rom;
        geometry_i <= cur_cmd.geometry;
        in_valid_i <= 1'b1;
        if (burst_left == 0) begin
          burst_left = ($urandom_range(0, 9) == 0) ? $urandom_range(30, 60)
                                                   : $urandom_range(1, 8);
        end
        burst_left--;
        if (burst_left == 0) begin
          gap_left = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 25)
                                                 : $urandom_range(0, 4);
        end
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // Stall the output on a changing pattern, with one long hold-off on request
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left--;
      out_stall_i <= 1'b1;
    end else if (hold_req && !hold_done) begin
      hold_done = 1'b1;
      hold_left = HoldCycles - 1;
      out_stall_i <= 1'b1;
    end else begin
      if (mode_left == 0) begin
        stall_mode = stall_mode_e'($urandom_range(0, 3));
        mode_left  = $urandom_range(20, 200);
      end
      mode_left--;
      stall_tick++;
      case (stall_mode)
        STALL_NONE:     out_stall_i <= 1'b0;
        STALL_LIGHT:    out_stall_i <= ($urandom_range(0, 99) < 30);
        STALL_HEAVY:    out_stall_i <= ($urandom_range(0, 99) < 70);
        default:        out_stall_i <= (stall_tick % 4 == 0);
      endcase
    end
  end

  task automatic push_cmd(input cmd_e cmd, input logic [7:0] pos, input logic [63:0] rom,
                          input logic [15:0] geom);
    probe_cmd_t c;
    c.cmd      = cmd;
    c.position = pos;
    c.rom      = rom;
    c.geometry = geom;
    cmd_q.push_back(c);
    queued_items++;
  endtask

  // Well-formed ROM: family byte, given serial bytes, matching CRC byte
  function automatic logic [63:0] rom_with_body(input logic [47:0] body);
    logic [63:0] r;
    r          = {8'h00, body, FamilyCode};
    r[63:56]   = rom_crc8(r);
    return r;
  endfunction

  function automatic logic [63:0] fresh_rom();
    return rom_with_body(48'({$urandom(), $urandom()}));
  endfunction

  function automatic logic [63:0] noise_word();
    return {$urandom(), $urandom()};
  endfunction

  // Wait until every command is accepted and every result beat is back
  task automatic wait_drained();
    do @(negedge clk_i);
    while (cmd_q.size() != 0 || in_valid_i || pending != 0);
  endtask

  task automatic cfg_write(input logic [15:0] value);
    @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= value;
    do @(posedge clk_i);
    while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    cfg_writes++;
    @(negedge clk_i);
  endtask

  // Begin, stage all positions shuffled with faults mixed in, finish or abort
  task automatic gen_table_sequence(input logic [15:0] acc);
    logic [63:0] roms [ProbeCount];
    int          order [ProbeCount];
    int          j;
    int          tmp;
    int          k;
    logic [15:0] geom;
    geom = ($urandom_range(0, 4) == 0) ? 16'($urandom()) : acc;
    push_cmd(CMD_BEGIN, 8'($urandom()), noise_word(), geom);
    for (int n = 0; n < ProbeCount; n++) begin
      order[n] = n;
    end
    for (int n = ProbeCount - 1; n > 0; n--) begin
      j        = $urandom_range(0, n);
      tmp      = order[n];
      order[n] = order[j];
      order[j] = tmp;
    end
    for (int n = 0; n < ProbeCount; n++) begin
      k       = order[n];
      roms[k] = fresh_rom();
      case ($urandom_range(0, 11))
        0: push_cmd(CMD_STAGE, 8'(k + 1), roms[k] ^ 64'($urandom_range(1, 255)),
                    16'($urandom()));
        1: push_cmd(CMD_STAGE, 8'(k + 1), roms[k] ^ (64'h1 << $urandom_range(56, 63)),
                    16'($urandom()));
        2: if (n > 0) begin
          push_cmd(CMD_STAGE, 8'(k + 1), roms[order[$urandom_range(0, n - 1)]],
                   16'($urandom()));
        end
        3: push_cmd(CMD_STAGE,
                    $urandom_range(0, 1) ? 8'd0 : 8'($urandom_range(ProbeCount + 1, 255)),
                    roms[k], 16'($urandom()));
        4: if ($urandom_range(0, 2) == 0) begin
          push_cmd(CMD_ABORT, 8'($urandom()), noise_word(), 16'($urandom()));
          if ($urandom_range(0, 1) == 0) begin
            return;
          end
        end
        default: ;
      endcase
      push_cmd(CMD_STAGE, 8'(k + 1), roms[k], 16'($urandom()));
      // Overwrite an already staged position now and then
      if ($urandom_range(0, 9) == 0) begin
        roms[k] = fresh_rom();
        push_cmd(CMD_STAGE, 8'(k + 1), roms[k], 16'($urandom()));
      end
    end
    push_cmd(CMD_FINISH, 8'($urandom()), noise_word(), 16'($urandom()));
    if ($urandom_range(0, 4) == 0) begin
      push_cmd(CMD_FINISH, 8'($urandom()), noise_word(), 16'($urandom()));
    end
  endtask

  // A few commands with random content in every field
  task automatic gen_noise();
    int count;
    count = $urandom_range(1, 4);
    for (int n = 0; n < count; n++) begin
      push_cmd(cmd_e'($urandom_range(0, 3)),
               $urandom_range(0, 1) ? 8'($urandom()) : 8'($urandom_range(0, ProbeCount + 1)),
               $urandom_range(0, 1) ? noise_word() : fresh_rom(),
               16'($urandom()));
    end
  endtask

  // Main sequence
  initial begin
    logic [63:0] first_rom;
    logic [15:0] geom_settings [6];

    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Directed, reset setting: every command, every status but bad geometry
    push_cmd(CMD_FINISH, 8'd0, 64'd0, 16'd0);
    push_cmd(CMD_STAGE, 8'd1, fresh_rom(), 16'd0);
    push_cmd(CMD_ABORT, 8'd0, 64'd0, 16'd0);
    push_cmd(CMD_BEGIN, 8'hFF, '1, AcceptedGeomReset);
    push_cmd(CMD_STAGE, 8'd0, fresh_rom(), 16'd0);
    push_cmd(CMD_STAGE, 8'(ProbeCount + 1), fresh_rom(), 16'd0);
    push_cmd(CMD_STAGE, 8'hFF, fresh_rom(), 16'hFFFF);
    push_cmd(CMD_STAGE, 8'd1, 64'd0, 16'd0);
    push_cmd(CMD_STAGE, 8'd1, '1, 16'd0);
    push_cmd(CMD_STAGE, 8'd1, fresh_rom() ^ {8'h01, 56'd0}, 16'd0);
    push_cmd(CMD_FINISH, 8'd0, 64'd0, 16'd0);
    first_rom = rom_with_body('0);
    push_cmd(CMD_STAGE, 8'd1, first_rom, 16'd0);
    push_cmd(CMD_STAGE, 8'd2, rom_with_body('1), 16'd0);
    for (int p = 3; p <= ProbeCount; p++) begin
      push_cmd(CMD_STAGE, 8'(p), fresh_rom(), 16'd0);
    end
    push_cmd(CMD_STAGE, 8'd3, first_rom, 16'd0);
    push_cmd(CMD_STAGE, 8'd1, first_rom, 16'd0);
    push_cmd(CMD_STAGE, 8'd4, fresh_rom(), 16'd0);
    push_cmd(CMD_FINISH, 8'd0, 64'd0, 16'd0);
    push_cmd(CMD_FINISH, 8'hFF, '1, 16'hFFFF);
    push_cmd(CMD_ABORT, 8'hFF, '1, 16'hFFFF);
    push_cmd(CMD_FINISH, 8'd0, 64'd0, 16'd0);

    // Random phases, one accepted geometry each, extremes included
    geom_settings[0] = 16'h0000;
    geom_settings[1] = 16'hFFFF;
    geom_settings[2] = 16'($urandom());
    geom_settings[3] = AcceptedGeomReset;
    geom_settings[4] = 16'($urandom());
    geom_settings[5] = 16'h8000;
    for (int p = 0; p < 6; p++) begin
      wait_drained();
      cfg_write(geom_settings[p]);
      // Back up the block once while the sender keeps offering
      if (p == 1) begin
        hold_req = 1'b1;
      end
      queued_items = 0;
      while (queued_items < PhaseItems) begin
        if ($urandom_range(0, 9) < 8) begin
          gen_table_sequence(geom_settings[p]);
        end else begin
          gen_noise();
        end
      end
    end

    wait_drained();
    repeat (40) @(posedge clk_i);
    @(negedge clk_i);
    $display("Covered %0d command beats, %0d result beats, %0d full table readouts",
             in_beats, out_beats, readouts);
    $display("over %0d geometry settings, with one %0d-cycle output hold-off",
             cfg_writes, HoldCycles);
    if (fail_count == 0 && pending == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #2_000_000;
    $display("Test completed with failures");
    $finish;
  end

endmodule
